@@ hw/rtl/rmfv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmfv_pkg: shared types and constants for the row mode finder
// Item and result layouts, cell control group, default sizing.
// ----------------------------------------------------------------------------
package rmfv_pkg;

    localparam int VALUE_WIDTH      = 32;
    localparam int MODE_COUNT_WIDTH = 7;
    localparam int ROW_CAPACITY     = 64;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last_in_row;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  mode_value;
        logic [MODE_COUNT_WIDTH-1:0]    mode_count;
        logic                           empty_row;
        logic                           overflow;
    } result_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic count_en;  // a counted nonzero item is on the broadcast bus
        logic new_en;    // no cell matched: first free cell takes the item
        logic shift;     // move every cell's contents one place toward the head
    } cell_ctrl_t;

endpackage : rmfv_pkg
`default_nettype wire

@@ hw/rtl/row_most_frequent_value.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// row_most_frequent_value: streaming row mode finder
// Counts nonzero row elements in a chain of cells and reports the most
// frequent value, first seen winning ties, at the end of each row.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge with start high and busy low, so a row
// streams in at one element per cycle. Every cell compares the broadcast value
// in parallel; a new value lands in the first free cell. After the item
// marked last_in_row, busy stays high while the chain drains into the head
// selector one cell per cycle, which also clears the chain. The result
// appears with done for exactly one cycle and must be taken then; the next
// row may start in that same cycle. Nonzero items beyond ROW_CAPACITY per row
// are not counted and raise overflow.
// ----------------------------------------------------------------------------
module row_most_frequent_value #(
    parameter int ROW_CAPACITY = rmfv_pkg::ROW_CAPACITY
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rmfv_pkg::item_t  item,
    output logic                  done,
    output rmfv_pkg::result_t     result
);
    import rmfv_pkg::*;

    localparam int COUNT_WIDTH = $clog2(ROW_CAPACITY + 1);
    localparam int EXT_WIDTH   = (COUNT_WIDTH > MODE_COUNT_WIDTH) ? COUNT_WIDTH
                                                                   : MODE_COUNT_WIDTH;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                   state_reg, state_next;
    logic [COUNT_WIDTH-1:0] items_seen_reg, items_seen_next;
    logic                   overflow_reg, overflow_next;
    logic [COUNT_WIDTH-1:0] best_count_reg, best_count_next;
    logic [VALUE_WIDTH-1:0] best_value_reg, best_value_next;
    logic                   done_reg, done_next;
    result_t                result_reg, result_next;

    logic                   accept;
    logic                   nonzero;
    logic                   room;
    logic                   any_hit;
    cell_ctrl_t             ctrl;
    logic [EXT_WIDTH-1:0]   best_ext;

    logic [ROW_CAPACITY-1:0] cell_valid;
    logic [ROW_CAPACITY-1:0] cell_hit;
    logic [VALUE_WIDTH-1:0]  cell_value [ROW_CAPACITY];
    logic [COUNT_WIDTH-1:0]  cell_count [ROW_CAPACITY];

    assign accept  = start && (state_reg == ST_IDLE);
    assign nonzero = (item.value != '0);
    assign room    = (items_seen_reg < COUNT_WIDTH'(ROW_CAPACITY));
    assign any_hit = |cell_hit;

    assign ctrl.count_en = accept && nonzero && room;
    assign ctrl.new_en   = accept && nonzero && room && !any_hit;
    assign ctrl.shift    = (state_reg == ST_SCAN);

    for (genvar i = 0; i < ROW_CAPACITY; i++)
    begin : g_cell
        logic                   prev_valid;
        logic                   next_valid;
        logic [VALUE_WIDTH-1:0] next_value;
        logic [COUNT_WIDTH-1:0] next_count;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[i-1];
        end

        // the tail refills with empty cells as the chain drains
        if (i == ROW_CAPACITY - 1)
        begin : g_tail
            assign next_valid = 1'b0;
            assign next_value = '0;
            assign next_count = '0;
        end
        else
        begin : g_link
            assign next_valid = cell_valid[i+1];
            assign next_value = cell_value[i+1];
            assign next_count = cell_count[i+1];
        end

        rmfv_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .bcast_value (item.value),
            .prev_valid  (prev_valid),
            .next_valid  (next_valid),
            .next_value  (next_value),
            .next_count  (next_count),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .count       (cell_count[i]),
            .hit         (cell_hit[i])
        );
    end

    assign best_ext = EXT_WIDTH'(best_count_reg);

    always_comb
    begin
        state_next      = state_reg;
        items_seen_next = items_seen_reg;
        overflow_next   = overflow_reg;
        best_count_next = best_count_reg;
        best_value_next = best_value_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (ctrl.count_en)
                    begin
                        items_seen_next = items_seen_reg + COUNT_WIDTH'(1);
                    end
                    if (nonzero && !room)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (item.last_in_row)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cell_valid[0])
                begin
                    // strict compare keeps the earliest value on a tie
                    if (cell_count[0] > best_count_reg)
                    begin
                        best_count_next = cell_count[0];
                        best_value_next = cell_value[0];
                    end
                end
                else
                begin
                    done_next              = 1'b1;
                    result_next.empty_row  = (best_count_reg == '0);
                    result_next.mode_value = (best_count_reg == '0) ? '0 : best_value_reg;
                    result_next.mode_count = best_ext[MODE_COUNT_WIDTH-1:0];
                    result_next.overflow   = overflow_reg;
                    best_count_next        = '0;
                    items_seen_next        = '0;
                    overflow_next          = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            items_seen_reg <= '0;
            overflow_reg   <= 1'b0;
            best_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            items_seen_reg <= items_seen_next;
            overflow_reg   <= overflow_next;
            best_count_reg <= best_count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_value_reg <= best_value_next;
        result_reg     <= result_next;
    end

    assign busy   = (state_reg == ST_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

endmodule : row_most_frequent_value
`default_nettype wire

@@ hw/rtl/rmfv_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmfv_cell: one cell of the value/count chain
// Holds one distinct value and its count, matches the broadcast item and
// hands its contents to the previous cell while the chain drains.
// ----------------------------------------------------------------------------
module rmfv_cell #(
    parameter int COUNT_WIDTH = 7
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire rmfv_pkg::cell_ctrl_t                ctrl,
    input  wire logic [rmfv_pkg::VALUE_WIDTH-1:0]    bcast_value,
    input  wire logic                                prev_valid,
    input  wire logic                                next_valid,
    input  wire logic [rmfv_pkg::VALUE_WIDTH-1:0]    next_value,
    input  wire logic [COUNT_WIDTH-1:0]              next_count,
    output logic                                     valid,
    output logic [rmfv_pkg::VALUE_WIDTH-1:0]         value,
    output logic [COUNT_WIDTH-1:0]                   count,
    output logic                                     hit
);
    import rmfv_pkg::*;

    logic                   valid_reg, valid_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    assign hit = valid_reg && (value_reg == bcast_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        count_next = count_reg;
        if (ctrl.shift)
        begin
            valid_next = next_valid;
            value_next = next_value;
            count_next = next_count;
        end
        else if (ctrl.count_en && hit)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        // valid cells are contiguous from the head, so only the first free one loads
        else if (ctrl.new_en && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            value_next = bcast_value;
            count_next = COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign count = count_reg;

endmodule : rmfv_cell
`default_nettype wire
